### hdl/ppid_pkg.sv
// Package for the positional PID servo controller with deadband.
// Holds widths, register reset values, register indexes and the shared payload types.
// No dependencies.
package ppid_pkg;

    localparam int unsigned SCALE_DEF = 1000;

    localparam int POS_W      = 32;
    localparam int ERR_W      = 21;
    localparam int INT_W      = 31;
    localparam int DER_W      = 22;
    localparam int GAIN_W     = 16;
    localparam int EC_W       = 20;
    localparam int IC_W       = 30;
    localparam int DC_W       = 15;
    localparam int DZ_W       = 16;
    localparam int DRV_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 30;
    localparam int PE_W       = GAIN_W + 1 + ERR_W;
    localparam int PI_W       = GAIN_W + 1 + INT_W;
    localparam int PD_W       = GAIN_W + 1 + DER_W;
    localparam int SUM_W      = 48;

    localparam logic [GAIN_W-1:0] GAIN_P_RST = GAIN_W'(250);
    localparam logic [GAIN_W-1:0] GAIN_I_RST = GAIN_W'(1);
    localparam logic [GAIN_W-1:0] GAIN_D_RST = GAIN_W'(80);
    localparam logic [EC_W-1:0]   ERR_CLAMP_RST = EC_W'(100000);
    localparam logic [IC_W-1:0]   INT_CLAMP_RST = IC_W'(200000);
    localparam logic [DC_W-1:0]   DRV_CLAMP_RST = DC_W'(999);
    localparam logic [DZ_W-1:0]   DEAD_ZONE_RST = DZ_W'(5);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P         = 3'd0,
        REG_GAIN_I         = 3'd1,
        REG_GAIN_D         = 3'd2,
        REG_ERROR_CLAMP    = 3'd3,
        REG_INTEGRAL_CLAMP = 3'd4,
        REG_DRIVE_CLAMP    = 3'd5,
        REG_DEAD_ZONE      = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_p;
        logic [GAIN_W-1:0] gain_i;
        logic [GAIN_W-1:0] gain_d;
        logic [EC_W-1:0]   error_clamp;
        logic [IC_W-1:0]   integral_clamp;
        logic [DC_W-1:0]   drive_clamp;
        logic [DZ_W-1:0]   dead_zone;
    } cfg_t;

    typedef struct packed {
        logic                    zero;
        logic                    dz;
        logic signed [ERR_W-1:0] err;
        logic signed [INT_W-1:0] integ;
        logic signed [DER_W-1:0] deriv;
    } law_t;

    typedef struct packed {
        logic                    zero;
        logic                    dz;
        logic signed [SUM_W-1:0] sum;
    } sum_t;

endpackage

### hdl/ppid_cfg.sv
// Configuration register file of the PID controller.
// Depends on ppid_pkg for the register indexes, widths and reset values.
module ppid_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ppid_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ppid_pkg::CFG_DATA_W-1:0]    cfg_data,
    output ppid_pkg::cfg_t                     cfg
);

    ppid_pkg::cfg_t cfg_reg;
    ppid_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (ppid_pkg::reg_idx_t'(cfg_index))
                ppid_pkg::REG_GAIN_P:
                    cfg_next.gain_p = cfg_data[ppid_pkg::GAIN_W-1:0];
                ppid_pkg::REG_GAIN_I:
                    cfg_next.gain_i = cfg_data[ppid_pkg::GAIN_W-1:0];
                ppid_pkg::REG_GAIN_D:
                    cfg_next.gain_d = cfg_data[ppid_pkg::GAIN_W-1:0];
                ppid_pkg::REG_ERROR_CLAMP:
                    cfg_next.error_clamp = cfg_data[ppid_pkg::EC_W-1:0];
                ppid_pkg::REG_INTEGRAL_CLAMP:
                    cfg_next.integral_clamp = cfg_data[ppid_pkg::IC_W-1:0];
                ppid_pkg::REG_DRIVE_CLAMP:
                    cfg_next.drive_clamp = cfg_data[ppid_pkg::DC_W-1:0];
                ppid_pkg::REG_DEAD_ZONE:
                    cfg_next.dead_zone = cfg_data[ppid_pkg::DZ_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p         <= ppid_pkg::GAIN_P_RST;
            cfg_reg.gain_i         <= ppid_pkg::GAIN_I_RST;
            cfg_reg.gain_d         <= ppid_pkg::GAIN_D_RST;
            cfg_reg.error_clamp    <= ppid_pkg::ERR_CLAMP_RST;
            cfg_reg.integral_clamp <= ppid_pkg::INT_CLAMP_RST;
            cfg_reg.drive_clamp    <= ppid_pkg::DRV_CLAMP_RST;
            cfg_reg.dead_zone      <= ppid_pkg::DEAD_ZONE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### hdl/ppid_law.sv
// Front of the PID pipeline: input register, error clamp, deadband test and history update.
// Depends on ppid_pkg for widths and the cfg_t and law_t types.
module ppid_law (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ppid_pkg::cfg_t                      cfg,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                in_action,
    input  logic signed [ppid_pkg::POS_W-1:0]   in_target,
    input  logic signed [ppid_pkg::POS_W-1:0]   in_measured,
    output logic                                out_valid,
    input  logic                                out_ready,
    output ppid_pkg::law_t                      out_data
);

    localparam int POS_W = ppid_pkg::POS_W;
    localparam int ERR_W = ppid_pkg::ERR_W;
    localparam int INT_W = ppid_pkg::INT_W;
    localparam int DER_W = ppid_pkg::DER_W;

    logic                    v0_reg;
    logic                    act0_reg;
    logic signed [POS_W-1:0] tgt0_reg;
    logic signed [POS_W-1:0] meas0_reg;
    logic                    rdy0;

    logic                    v1_reg;
    logic                    act1_reg;
    logic signed [ERR_W-1:0] err1_reg;
    logic signed [ERR_W-1:0] err1_next;
    logic                    rdy1;

    logic                    v2_reg;
    ppid_pkg::law_t          law_reg;
    ppid_pkg::law_t          law_next;
    logic                    rdy2;

    logic signed [INT_W-1:0] acc_reg;
    logic signed [INT_W-1:0] acc_next;
    logic signed [ERR_W-1:0] prev_reg;
    logic signed [ERR_W-1:0] prev_next;

    logic signed [POS_W:0]   diff;
    logic signed [POS_W:0]   ec_pos;
    logic [ERR_W-1:0]        err_abs;
    logic                    dz_hit;
    logic signed [INT_W:0]   isum;
    logic signed [INT_W:0]   ic_pos;
    logic signed [INT_W-1:0] integ_c;
    logic signed [DER_W-1:0] deriv;

    assign rdy0      = !v0_reg || rdy1;
    assign rdy1      = !v1_reg || rdy2;
    assign rdy2      = !v2_reg || out_ready;
    assign in_ready  = rdy0;
    assign out_valid = v2_reg;
    assign out_data  = law_reg;

    always_comb
    begin
        diff   = (POS_W+1)'(tgt0_reg) - (POS_W+1)'(meas0_reg);
        ec_pos = $signed((POS_W+1)'(cfg.error_clamp));
        if (diff > ec_pos)
        begin
            err1_next = ERR_W'(ec_pos);
        end
        else if (diff < -ec_pos)
        begin
            err1_next = ERR_W'(-ec_pos);
        end
        else
        begin
            err1_next = ERR_W'(diff);
        end
    end

    always_comb
    begin
        err_abs = err1_reg[ERR_W-1] ? ERR_W'(-err1_reg) : ERR_W'(err1_reg);
        dz_hit  = err_abs <= ERR_W'(cfg.dead_zone);
        isum    = (INT_W+1)'(acc_reg) + (INT_W+1)'(err1_reg);
        ic_pos  = $signed((INT_W+1)'(cfg.integral_clamp));
        if (isum > ic_pos)
        begin
            integ_c = INT_W'(ic_pos);
        end
        else if (isum < -ic_pos)
        begin
            integ_c = INT_W'(-ic_pos);
        end
        else
        begin
            integ_c = INT_W'(isum);
        end
        deriv = DER_W'(err1_reg) - DER_W'(prev_reg);

        law_next.zero  = act1_reg || dz_hit;
        law_next.dz    = !act1_reg && dz_hit;
        law_next.err   = err1_reg;
        law_next.integ = integ_c;
        law_next.deriv = deriv;

        if (act1_reg)
        begin
            acc_next  = '0;
            prev_next = '0;
        end
        else if (dz_hit)
        begin
            acc_next  = '0;
            prev_next = err1_reg;
        end
        else
        begin
            acc_next  = integ_c;
            prev_next = err1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            acc_reg  <= '0;
            prev_reg <= '0;
        end
        else
        begin
            if (rdy0)
            begin
                v0_reg <= in_valid;
            end
            if (rdy1)
            begin
                v1_reg <= v0_reg;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (v1_reg && rdy2)
            begin
                acc_reg  <= acc_next;
                prev_reg <= prev_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && rdy0)
        begin
            act0_reg  <= in_action;
            tgt0_reg  <= in_target;
            meas0_reg <= in_measured;
        end
        if (v0_reg && rdy1)
        begin
            act1_reg <= act0_reg;
            err1_reg <= err1_next;
        end
        if (v1_reg && rdy2)
        begin
            law_reg <= law_next;
        end
    end

`ifndef SYNTHESIS
    a_clear_history: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && rdy2 && act1_reg) |=> (acc_reg == '0 && prev_reg == '0))
        else $error("History not cleared after a clear request.");

    a_deadband_history: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && rdy2 && !act1_reg && dz_hit)
        |=> (acc_reg == '0 && prev_reg == $past(err1_reg)))
        else $error("Deadband request did not reset the integral and keep the error.");

    a_history_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !(v1_reg && rdy2) |=> ($stable(acc_reg) && $stable(prev_reg)))
        else $error("History changed without a request entering the update stage.");

    a_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && rdy2 && act1_reg) |=> (v2_reg && law_reg.zero && !law_reg.dz))
        else $error("Clear request not marked for a zero drive.");
`endif

endmodule

### hdl/ppid_mac.sv
// Gain multiplications and sum of the three PID terms, two pipeline stages.
// Depends on ppid_pkg for widths and the cfg_t, law_t and sum_t types.
module ppid_mac (
    input  logic           clk,
    input  logic           rst_n,
    input  ppid_pkg::cfg_t cfg,
    input  logic           in_valid,
    output logic           in_ready,
    input  ppid_pkg::law_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output ppid_pkg::sum_t out_data
);

    localparam int PE_W  = ppid_pkg::PE_W;
    localparam int PI_W  = ppid_pkg::PI_W;
    localparam int PD_W  = ppid_pkg::PD_W;
    localparam int SUM_W = ppid_pkg::SUM_W;

    logic                   vp_reg;
    logic                   zp_reg;
    logic                   dzp_reg;
    logic signed [PE_W-1:0] pe_reg;
    logic signed [PI_W-1:0] pi_reg;
    logic signed [PD_W-1:0] pd_reg;
    logic signed [PE_W-1:0] pe_next;
    logic signed [PI_W-1:0] pi_next;
    logic signed [PD_W-1:0] pd_next;
    logic                   rdyp;

    logic                   vs_reg;
    ppid_pkg::sum_t         sum_reg;
    ppid_pkg::sum_t         sum_next;
    logic                   rdys;

    assign rdyp      = !vp_reg || rdys;
    assign rdys      = !vs_reg || out_ready;
    assign in_ready  = rdyp;
    assign out_valid = vs_reg;
    assign out_data  = sum_reg;

    always_comb
    begin
        pe_next = $signed({1'b0, cfg.gain_p}) * in_data.err;
        pi_next = $signed({1'b0, cfg.gain_i}) * in_data.integ;
        pd_next = $signed({1'b0, cfg.gain_d}) * in_data.deriv;

        sum_next.zero = zp_reg;
        sum_next.dz   = dzp_reg;
        sum_next.sum  = SUM_W'(pe_reg) + SUM_W'(pi_reg) + SUM_W'(pd_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp_reg <= 1'b0;
            vs_reg <= 1'b0;
        end
        else
        begin
            if (rdyp)
            begin
                vp_reg <= in_valid;
            end
            if (rdys)
            begin
                vs_reg <= vp_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && rdyp)
        begin
            zp_reg  <= in_data.zero;
            dzp_reg <= in_data.dz;
            pe_reg  <= pe_next;
            pi_reg  <= pi_next;
            pd_reg  <= pd_next;
        end
        if (vp_reg && rdys)
        begin
            sum_reg <= sum_next;
        end
    end

endmodule

### hdl/ppid_scale.sv
// Division of the PID sum by SCALE, truncating toward zero, and the drive clamp.
// Uses a reciprocal multiply with one correction step; depends on ppid_pkg.
module ppid_scale #(
    parameter int unsigned SCALE = ppid_pkg::SCALE_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [ppid_pkg::DC_W-1:0]          drive_clamp,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  ppid_pkg::sum_t                     in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [ppid_pkg::DRV_W-1:0]  out_drive,
    output logic                               out_dz
);

    localparam int SUM_W   = ppid_pkg::SUM_W;
    localparam int DC_W    = ppid_pkg::DC_W;
    localparam int DRV_W   = ppid_pkg::DRV_W;
    localparam int SCALE_W = $clog2(SCALE + 1);
    localparam int X_W     = $clog2(SCALE) + DC_W;
    localparam int PR_W    = 2 * X_W + 1;

    localparam logic [SUM_W-1:0]   SAT_LIM = SUM_W'(64'(SCALE) << DC_W);
    localparam logic [X_W:0]       RECIP   = (X_W+1)'((64'd1 << X_W) / SCALE);
    localparam logic [SCALE_W-1:0] SCALE_V = SCALE_W'(SCALE);
    localparam logic [X_W-1:0]     SCALE_X = X_W'(SCALE);

    typedef struct packed {
        logic zero;
        logic dz;
        logic neg;
        logic sat;
    } sflag_t;

    logic                  ve_reg;
    sflag_t                fe_reg;
    sflag_t                fe_next;
    logic [X_W-1:0]        xe_reg;
    logic [SUM_W-1:0]      mag;
    logic                  rdye;

    logic                  vf_reg;
    sflag_t                ff_reg;
    logic [X_W-1:0]        xf_reg;
    logic [DC_W-1:0]       q0f_reg;
    logic [PR_W-1:0]       prod;
    logic                  rdyf;

    logic                  vg_reg;
    sflag_t                fg_reg;
    logic [X_W-1:0]        xg_reg;
    logic [DC_W-1:0]       q0g_reg;
    logic [X_W-1:0]        pg_reg;
    logic [X_W-1:0]        pg_next;
    logic                  rdyg;

    logic                  vo_reg;
    logic signed [DRV_W-1:0] drive_reg;
    logic signed [DRV_W-1:0] drive_next;
    logic                  dz_reg;
    logic [X_W-1:0]        rem;
    logic [DC_W:0]         quot;
    logic [DC_W-1:0]       dmag;
    logic                  rdyo;

    assign rdye      = !ve_reg || rdyf;
    assign rdyf      = !vf_reg || rdyg;
    assign rdyg      = !vg_reg || rdyo;
    assign rdyo      = !vo_reg || out_ready;
    assign in_ready  = rdye;
    assign out_valid = vo_reg;
    assign out_drive = drive_reg;
    assign out_dz    = dz_reg;

    always_comb
    begin
        mag          = in_data.sum[SUM_W-1] ? SUM_W'(-in_data.sum) : SUM_W'(in_data.sum);
        fe_next.zero = in_data.zero;
        fe_next.dz   = in_data.dz;
        fe_next.neg  = in_data.sum[SUM_W-1];
        fe_next.sat  = mag >= SAT_LIM;
    end

    always_comb
    begin
        prod    = PR_W'(xe_reg) * PR_W'(RECIP);
        pg_next = X_W'(q0f_reg * SCALE_V);
    end

    always_comb
    begin
        rem  = xg_reg - pg_reg;
        quot = (DC_W+1)'(q0g_reg) + (DC_W+1)'(rem >= SCALE_X);
        if (fg_reg.sat || (quot > (DC_W+1)'(drive_clamp)))
        begin
            dmag = drive_clamp;
        end
        else
        begin
            dmag = DC_W'(quot);
        end
        if (fg_reg.zero)
        begin
            drive_next = '0;
        end
        else if (fg_reg.neg)
        begin
            drive_next = -$signed(DRV_W'(dmag));
        end
        else
        begin
            drive_next = $signed(DRV_W'(dmag));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ve_reg <= 1'b0;
            vf_reg <= 1'b0;
            vg_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (rdye)
            begin
                ve_reg <= in_valid;
            end
            if (rdyf)
            begin
                vf_reg <= ve_reg;
            end
            if (rdyg)
            begin
                vg_reg <= vf_reg;
            end
            if (rdyo)
            begin
                vo_reg <= vg_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && rdye)
        begin
            fe_reg <= fe_next;
            xe_reg <= X_W'(mag);
        end
        if (ve_reg && rdyf)
        begin
            ff_reg  <= fe_reg;
            xf_reg  <= xe_reg;
            q0f_reg <= prod[X_W +: DC_W];
        end
        if (vf_reg && rdyg)
        begin
            fg_reg  <= ff_reg;
            xg_reg  <= xf_reg;
            q0g_reg <= q0f_reg;
            pg_reg  <= pg_next;
        end
        if (vg_reg && rdyo)
        begin
            drive_reg <= drive_next;
            dz_reg    <= fg_reg.dz;
        end
    end

endmodule

### hdl/position_pid_with_deadband_core.sv
// Positional PID servo controller with error clamp, deadband and integral anti-windup.
// Top level: joins ppid_cfg, ppid_law, ppid_mac and ppid_scale; depends on ppid_pkg.
//
// Usage. Each request on the slave channel is a clear (s_tuser high) or an update with a
// target and a measured position in s_tdata. Every request gives exactly one result on the
// master channel: the drive in m_tdata and the deadband flag in m_tuser. A clear empties
// the integral and the stored error and returns a drive of zero.
// The pipeline has nine register stages. One request is accepted in every cycle as long
// as the receiver does not hold m_tready low while all stages are occupied; the
// integral and the stored error are updated in a single stage, so consecutive requests
// see each other's history without gaps. The gain products and the division by SCALE,
// a reciprocal multiply with one correction, are spread over the later stages.
// When the receiver holds m_tready low, each stage keeps its request and empty stages
// still fill, so s_tready falls only when all nine stages are occupied.
// The configuration channel is always ready and should be written only while no request
// is in flight. Reset clears all stages, the history and the registers to their defaults.
module position_pid_with_deadband_core #(
    parameter int unsigned SCALE = ppid_pkg::SCALE_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [63:0]                        s_tdata,    // target_pos, measured_pos
    input  logic                               s_tuser,    // action
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [15:0]                        m_tdata,    // drive
    output logic                               m_tuser,    // in_dead_zone
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ppid_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ppid_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int POS_W = ppid_pkg::POS_W;

    ppid_pkg::cfg_t               cfg;
    logic                         law_valid;
    logic                         law_ready;
    ppid_pkg::law_t               law_data;
    logic                         sum_valid;
    logic                         sum_ready;
    ppid_pkg::sum_t               sum_data;
    logic signed [ppid_pkg::DRV_W-1:0] drive;

    assign m_tdata = drive;

    ppid_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ppid_law u_law (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_action   (s_tuser),
        .in_target   ($signed(s_tdata[POS_W-1:0])),
        .in_measured ($signed(s_tdata[2*POS_W-1:POS_W])),
        .out_valid   (law_valid),
        .out_ready   (law_ready),
        .out_data    (law_data)
    );

    ppid_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (law_valid),
        .in_ready  (law_ready),
        .in_data   (law_data),
        .out_valid (sum_valid),
        .out_ready (sum_ready),
        .out_data  (sum_data)
    );

    ppid_scale #(
        .SCALE (SCALE)
    ) u_scale (
        .clk         (clk),
        .rst_n       (rst_n),
        .drive_clamp (cfg.drive_clamp),
        .in_valid    (sum_valid),
        .in_ready    (sum_ready),
        .in_data     (sum_data),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_drive   (drive),
        .out_dz      (m_tuser)
    );

endmodule
